// File: rtl/rsl_pkg.sv
// Shared types and constants for the ranked sorted list.
`timescale 1ns / 1ps
`default_nettype none

package rsl_pkg;

    localparam int POS_BITS = 10;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_ENC1,
        ST_ENC2
    } t_state;

    // Broadcast to every cell during the shift cycle.
    typedef struct packed {
        logic ins;
        logic rem;
    } t_cell_ctl;

endpackage

`default_nettype wire

// File: rtl/rsl_cell.sv
// One list slot: holds a key, compares it and shifts with its neighbors.
`timescale 1ns / 1ps
`default_nettype none

module rsl_cell
    import rsl_pkg::*;
#(
    parameter int KEY_BITS = 17,
    parameter int CNT_BITS = 11,
    parameter int CELL_IDX = 0
) (
    input  wire                 i_clk,
    input  t_cell_ctl           i_ctl,
    input  wire [KEY_BITS-1:0]  i_new_key,
    input  wire [CNT_BITS-1:0]  i_count,
    input  wire [CNT_BITS-1:0]  i_rem_idx,
    input  wire [KEY_BITS-1:0]  i_left_key,
    input  wire [KEY_BITS-1:0]  i_right_key,
    input  wire                 i_left_ge,
    output logic [KEY_BITS-1:0] o_key,
    output logic                o_ge,
    output logic                o_hit
);

    localparam logic [CNT_BITS-1:0] MY_POS = CNT_BITS'(CELL_IDX);

    logic [KEY_BITS-1:0] r_key;
    logic [KEY_BITS-1:0] n_key;
    logic                w_valid;

    assign w_valid = MY_POS < i_count;
    // Valid keys >= new key form a prefix; the first cell past it is the slot.
    assign o_ge    = w_valid && (r_key >= i_new_key);
    assign o_hit   = !o_ge && i_left_ge;
    assign o_key   = r_key;

    always_comb begin
        n_key = r_key;
        if (i_ctl.ins) begin
            if (o_ge) begin
                n_key = r_key;
            end else if (o_hit) begin
                n_key = i_new_key;
            end else begin
                n_key = i_left_key;
            end
        end else if (i_ctl.rem) begin
            if (MY_POS >= i_rem_idx) begin
                n_key = i_right_key;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

endmodule

`default_nettype wire

// File: rtl/rsl_encode.sv
// Two-stage one-hot to binary encoder for the insert slot.
`timescale 1ns / 1ps
`default_nettype none

module rsl_encode
    import rsl_pkg::*;
#(
    parameter int CAPACITY = 1024,
    parameter int IDX_BITS = 10
) (
    input  wire                 i_clk,
    input  wire                 i_load,
    input  wire [CAPACITY-1:0]  i_hit,
    output logic [IDX_BITS-1:0] o_rank
);

    localparam int HI_BITS = IDX_BITS / 2;
    localparam int LO_BITS = IDX_BITS - HI_BITS;
    localparam int GS      = 1 << LO_BITS;
    localparam int NG      = 1 << HI_BITS;
    localparam int PAD     = NG * GS;

    logic [PAD-1:0]     r_hit;
    logic [LO_BITS-1:0] r_lo  [NG];
    logic [NG-1:0]      r_grp;
    logic [LO_BITS-1:0] n_lo  [NG];
    logic [NG-1:0]      n_grp;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_hit <= PAD'(i_hit);
        end
    end

    // Stage 1: index within each group.
    always_comb begin
        for (int g = 0; g < NG; g++) begin
            n_lo[g]  = '0;
            n_grp[g] = |r_hit[g*GS +: GS];
            for (int j = 0; j < GS; j++) begin
                if (r_hit[g*GS + j]) begin
                    n_lo[g] = n_lo[g] | LO_BITS'(j);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_grp <= n_grp;
        for (int g = 0; g < NG; g++) begin
            r_lo[g] <= n_lo[g];
        end
    end

    // Stage 2: merge groups; exactly one group hits.
    always_comb begin
        o_rank = '0;
        for (int g = 0; g < NG; g++) begin
            if (r_grp[g]) begin
                o_rank = o_rank | (IDX_BITS'(g) << LO_BITS) | IDX_BITS'(r_lo[g]);
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/ranked_sorted_list.sv
// Top level of the ranked sorted list.
//
// Keeps up to CAPACITY keys sorted largest first, one key per cell in a row
// of cells. A request is taken at a clock edge with i_start high and o_busy
// low. i_mode selects insert (i_key_value) or remove (i_remove_index).
// An insert yields one result: o_result_valid is high for one cycle with
// o_insert_position (number of stored keys >= the new key) and o_status
// (0 inserted, 1 list full and key dropped, position 0).
// A remove yields no result; an index at or past the count is ignored.
// Sequence from the accept edge: an insert passes the shift state, then the
// encoder states ST_ENC1 and ST_ENC2, and its strobe is registered out of
// ST_ENC2. A full insert registers its strobe out of the shift state; a
// remove is busy only for the shift state.
// All cells compare and shift together in the shift cycle; the slot index
// is recovered by a two-level registered one-hot encoder, which sets the
// insert latency. o_busy drops in the cycle the strobe shows, so the next
// request may be taken then. Results cannot be stalled.
// Synchronous active-low reset empties the list; key storage is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module ranked_sorted_list
    import rsl_pkg::*;
#(
    parameter int CAPACITY = 1024,
    parameter int KEY_BITS = 17
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_start,
    output logic                o_busy,
    input  wire                 i_mode,
    input  wire [KEY_BITS-1:0]  i_key_value,
    input  wire [POS_BITS-1:0]  i_remove_index,
    output logic                o_result_valid,
    output logic [POS_BITS-1:0] o_insert_position,
    output logic                o_status
);

    localparam int IDX_BITS = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_BITS = $clog2(CAPACITY + 1);
    localparam int CMP_BITS = (CNT_BITS > POS_BITS) ? CNT_BITS : POS_BITS;
    localparam logic [CNT_BITS-1:0] FULL_COUNT = CNT_BITS'(CAPACITY);

    t_state              r_state;
    t_state              n_state;
    logic                r_mode;
    logic [KEY_BITS-1:0] r_key;
    logic [POS_BITS-1:0] r_idx;
    logic [CNT_BITS-1:0] r_count;
    logic [CNT_BITS-1:0] n_count;
    logic                r_out_valid;
    logic                n_out_valid;
    logic [POS_BITS-1:0] r_out_pos;
    logic [POS_BITS-1:0] n_out_pos;
    logic                r_out_status;
    logic                n_out_status;

    logic                w_accept;
    logic                w_full;
    logic                w_rem_ok;
    logic                w_load;
    t_cell_ctl           w_ctl;
    logic [KEY_BITS-1:0] w_keys [CAPACITY];
    logic [CAPACITY-1:0] w_ge;
    logic [CAPACITY-1:0] w_hit;
    logic [IDX_BITS-1:0] w_rank;

    assign w_accept = i_start && (r_state == ST_IDLE);
    assign w_full   = (r_count == FULL_COUNT);
    assign w_rem_ok = CMP_BITS'(r_idx) < CMP_BITS'(r_count);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_SHIFT;
                end
            end
            ST_SHIFT: begin
                if (r_mode == MODE_INSERT && !w_full) begin
                    n_state = ST_ENC1;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_ENC1: n_state = ST_ENC2;
            ST_ENC2: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        w_ctl        = '0;
        w_load       = 1'b0;
        n_count      = r_count;
        n_out_valid  = 1'b0;
        n_out_pos    = r_out_pos;
        n_out_status = r_out_status;
        unique case (r_state)
            ST_IDLE: begin
            end
            ST_SHIFT: begin
                if (r_mode == MODE_REMOVE) begin
                    if (w_rem_ok) begin
                        w_ctl.rem = 1'b1;
                        n_count   = r_count - CNT_BITS'(1);
                    end
                end else if (w_full) begin
                    n_out_valid  = 1'b1;
                    n_out_pos    = '0;
                    n_out_status = STATUS_FULL;
                end else begin
                    w_ctl.ins = 1'b1;
                    w_load    = 1'b1;
                    n_count   = r_count + CNT_BITS'(1);
                end
            end
            ST_ENC1: begin
            end
            ST_ENC2: begin
                n_out_valid  = 1'b1;
                n_out_pos    = POS_BITS'(w_rank);
                n_out_status = STATUS_OK;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode <= i_mode;
            r_key  <= i_key_value;
            r_idx  <= i_remove_index;
        end
        r_out_pos    <= n_out_pos;
        r_out_status <= n_out_status;
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic [KEY_BITS-1:0] w_left_key;
            logic [KEY_BITS-1:0] w_right_key;
            logic                w_left_ge;

            if (gi == 0) begin : g_first
                assign w_left_key = r_key;
                assign w_left_ge  = 1'b1;
            end else begin : g_inner
                assign w_left_key = w_keys[gi-1];
                assign w_left_ge  = w_ge[gi-1];
            end

            if (gi == CAPACITY - 1) begin : g_last
                assign w_right_key = w_keys[gi];
            end else begin : g_mid
                assign w_right_key = w_keys[gi+1];
            end

            rsl_cell #(
                .KEY_BITS (KEY_BITS),
                .CNT_BITS (CNT_BITS),
                .CELL_IDX (gi)
            ) u_cell (
                .i_clk       (i_clk),
                .i_ctl       (w_ctl),
                .i_new_key   (r_key),
                .i_count     (r_count),
                .i_rem_idx   (CNT_BITS'(r_idx)),
                .i_left_key  (w_left_key),
                .i_right_key (w_right_key),
                .i_left_ge   (w_left_ge),
                .o_key       (w_keys[gi]),
                .o_ge        (w_ge[gi]),
                .o_hit       (w_hit[gi])
            );
        end
    endgenerate

    rsl_encode #(
        .CAPACITY (CAPACITY),
        .IDX_BITS (IDX_BITS)
    ) u_encode (
        .i_clk  (i_clk),
        .i_load (w_load),
        .i_hit  (w_hit),
        .o_rank (w_rank)
    );

    assign o_busy            = (r_state != ST_IDLE);
    assign o_result_valid    = r_out_valid;
    assign o_insert_position = r_out_pos;
    assign o_status          = r_out_status;

endmodule

`default_nettype wire
